// ===== src/pfwsd_pkg.sv =====
// shared types, constants and the wheel sign table of the four-wheel speed drive
// depends on nothing; every other file uses it
package pfwsd_pkg;

    localparam int COUNT_WIDTH_DEF  = 32;
    localparam int PORT_COUNT_WIDTH = 32;
    localparam int TIME_WIDTH       = 20;
    localparam int TICK_WIDTH       = 24;
    localparam int CRUISE_WIDTH     = 8;
    localparam int GAIN_WIDTH       = 16;
    localparam int POWER_WIDTH      = 8;
    localparam int DIR_WIDTH        = 4;
    localparam int CFG_INDEX_WIDTH  = 3;
    localparam int CFG_DATA_WIDTH   = 24;
    localparam int NUM_WHEELS       = 4;
    localparam int QUOT_WIDTH       = 8;
    localparam int NUM_WIDTH        = 32;

    localparam logic [11:0]           BACK_SCALE_Q10  = 12'd1411;
    localparam logic [GAIN_WIDTH-1:0] DROPPED_GAIN_Q8 = 16'd1280;

    // register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIRECTION = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TOTAL     = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_CRUISE    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE      = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ACCEL     = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DECEL     = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_GAIN      = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIMEOUT   = 3'd7;

    // drive directions
    localparam logic [DIR_WIDTH-1:0] DIR_FWD        = 4'd1;
    localparam logic [DIR_WIDTH-1:0] DIR_RIGHT      = 4'd2;
    localparam logic [DIR_WIDTH-1:0] DIR_BACK       = 4'd3;
    localparam logic [DIR_WIDTH-1:0] DIR_LEFT       = 4'd4;
    localparam logic [DIR_WIDTH-1:0] DIR_FWD_RIGHT  = 4'd5;
    localparam logic [DIR_WIDTH-1:0] DIR_BACK_RIGHT = 4'd6;
    localparam logic [DIR_WIDTH-1:0] DIR_BACK_LEFT  = 4'd7;
    localparam logic [DIR_WIDTH-1:0] DIR_FWD_LEFT   = 4'd8;

    typedef enum logic [1:0] {
        SIGN_ZERO = 2'd0,
        SIGN_POS  = 2'd1,
        SIGN_NEG  = 2'd2
    } sign_t;

    // element 0 is front left, then front right, back left, back right
    typedef sign_t [NUM_WHEELS-1:0] sign_row_t;

    typedef struct packed {
        logic load_mag;
        logic load_err;
        logic load_prod;
        logic commit;
        logic clear;
    } lane_ctl_t;

    function automatic sign_row_t wheel_signs(input logic [DIR_WIDTH-1:0] dir);
        sign_row_t r;
        r = {SIGN_ZERO, SIGN_ZERO, SIGN_ZERO, SIGN_ZERO};
        case (dir)
            DIR_FWD:        r = {SIGN_POS,  SIGN_POS,  SIGN_POS,  SIGN_POS};
            DIR_RIGHT:      r = {SIGN_POS,  SIGN_NEG,  SIGN_NEG,  SIGN_POS};
            DIR_BACK:       r = {SIGN_NEG,  SIGN_NEG,  SIGN_NEG,  SIGN_NEG};
            DIR_LEFT:       r = {SIGN_NEG,  SIGN_POS,  SIGN_POS,  SIGN_NEG};
            DIR_FWD_RIGHT:  r = {SIGN_POS,  SIGN_ZERO, SIGN_ZERO, SIGN_POS};
            DIR_BACK_RIGHT: r = {SIGN_ZERO, SIGN_NEG,  SIGN_NEG,  SIGN_ZERO};
            DIR_BACK_LEFT:  r = {SIGN_NEG,  SIGN_ZERO, SIGN_ZERO, SIGN_NEG};
            DIR_FWD_LEFT:   r = {SIGN_ZERO, SIGN_POS,  SIGN_POS,  SIGN_ZERO};
            default:        r = {SIGN_ZERO, SIGN_ZERO, SIGN_ZERO, SIGN_ZERO};
        endcase
        return r;
    endfunction

endpackage

// ===== src/pfwsd_if.sv =====
// channel interfaces: tick words in, power words out
// depends on pfwsd_pkg for field widths
interface pfwsd_tick_if;
    logic valid;
    logic ready;
    logic action;
    logic signed [pfwsd_pkg::PORT_COUNT_WIDTH-1:0] count_front_left;
    logic signed [pfwsd_pkg::PORT_COUNT_WIDTH-1:0] count_front_right;
    logic signed [pfwsd_pkg::PORT_COUNT_WIDTH-1:0] count_back_left;
    logic signed [pfwsd_pkg::PORT_COUNT_WIDTH-1:0] count_back_right;
    logic [pfwsd_pkg::TIME_WIDTH-1:0] elapsed_ms;

    modport source (output valid, action, count_front_left, count_front_right,
                    count_back_left, count_back_right, elapsed_ms, input ready);
    modport sink (input valid, action, count_front_left, count_front_right,
                  count_back_left, count_back_right, elapsed_ms, output ready);
endinterface

interface pfwsd_power_if;
    logic valid;
    logic ready;
    logic signed [pfwsd_pkg::POWER_WIDTH-1:0] power_front_left;
    logic signed [pfwsd_pkg::POWER_WIDTH-1:0] power_front_right;
    logic signed [pfwsd_pkg::POWER_WIDTH-1:0] power_back_left;
    logic signed [pfwsd_pkg::POWER_WIDTH-1:0] power_back_right;
    logic done_res;
    logic timed_out;

    modport source (output valid, power_front_left, power_front_right, power_back_left,
                    power_back_right, done_res, timed_out, input ready);
    modport sink (input valid, power_front_left, power_front_right, power_back_left,
                  power_back_right, done_res, timed_out, output ready);
endinterface

// ===== src/profiled_four_wheel_speed_drive_unit.sv =====
// top level of the profiled four-wheel speed drive: config registers, sequencer,
// four wheel lanes, ramp divider and merging stage
// depends on pfwsd_pkg, pfwsd_if, pfwsd_div, pfwsd_lane, pfwsd_merge
//
//   channel   dir  handshake      contents
//   tick      in   valid/ready    action, four wheel counts, elapsed_ms
//   drive     out  valid/ready    four wheel powers, done_res, timed_out
//   cfg       in   cfg_we only    cfg_index selects register, cfg_data
//
// a control tick on a ramp passes from acceptance to the result register through
// setup, ramp numerator multiply, 8 divider steps for the ramp target, error, product
// and final stage; a cruise tick skips the divider; start words and words after the
// move ended go straight to the final stage
// one word is in work at a time; the next word is taken while a result waits
// rst_n clears the sequencer, move state and registers to their defaults
// a stalled drive channel holds the final stage until the result register frees
module profiled_four_wheel_speed_drive_unit #(
    parameter int COUNT_WIDTH = pfwsd_pkg::COUNT_WIDTH_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    pfwsd_tick_if.sink                               tick,
    pfwsd_power_if.source                            drive,
    input  logic                                     cfg_we,
    input  logic [pfwsd_pkg::CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [pfwsd_pkg::CFG_DATA_WIDTH-1:0]     cfg_data
);
    import pfwsd_pkg::*;

    localparam int CMP_W = ((COUNT_WIDTH > TICK_WIDTH) ? COUNT_WIDTH : TICK_WIDTH) + 1;

    // sequencer states
    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SETUP = 7'b0000010,
        S_MUL   = 7'b0000100,
        S_DIV   = 7'b0001000,
        S_ERR   = 7'b0010000,
        S_PROD  = 7'b0100000,
        S_FINAL = 7'b1000000
    } state_t;

    // what the accepted word turns out to be
    typedef enum logic [1:0] {
        K_START  = 2'd0,
        K_REPEAT = 2'd1,
        K_DIST   = 2'd2,
        K_RUN    = 2'd3
    } kind_t;

    state_t state_reg, state_next;
    kind_t  kind_reg;

    // configuration registers
    logic [DIR_WIDTH-1:0]          dir_reg;
    logic [TICK_WIDTH-1:0]         total_reg, accel_reg, decel_reg;
    logic [CRUISE_WIDTH-1:0]       cruise_reg;
    logic signed [POWER_WIDTH-1:0] base_reg;
    logic [GAIN_WIDTH-1:0]         gain_reg;
    logic [TIME_WIDTH-1:0]         timeout_reg;

    // move state
    logic [COUNT_WIDTH-1:0] travelled_reg;
    logic                   gain_dropped_reg, finished_reg, timeout_flag_reg;

    // latched word
    logic [PORT_COUNT_WIDTH-1:0] count_reg [NUM_WHEELS];
    logic [TIME_WIDTH-1:0]       elapsed_reg;

    // ramp selection
    logic                  in_accel_reg, in_decel_reg;
    logic [TICK_WIDTH-1:0] x_reg;
    logic [CMP_W-1:0]      t_ext;
    logic                  in_accel, in_decel, dist_reached;
    logic [TICK_WIDTH-1:0] x_next;

    // output register
    logic                          out_valid_reg;
    logic signed [POWER_WIDTH-1:0] out_power_reg [NUM_WHEELS];
    logic                          out_done_reg, out_to_reg;

    logic      accept, out_free, final_fire, timed_now;
    lane_ctl_t lane_ctl;
    logic      div_start, div_done;
    logic [QUOT_WIDTH-1:0]   quot;
    logic [NUM_WIDTH-1:0]    num;
    logic [CRUISE_WIDTH-1:0] target;
    logic [GAIN_WIDTH-1:0]   g_used;

    logic [COUNT_WIDTH-1:0]        lane_mag [NUM_WHEELS];
    logic signed [POWER_WIDTH-1:0] lane_power [NUM_WHEELS];
    logic signed [POWER_WIDTH-1:0] drive_power [NUM_WHEELS];
    logic [COUNT_WIDTH-1:0]        travelled_new;

    assign tick.ready = (state_reg == S_IDLE);
    assign accept     = tick.valid && tick.ready;
    assign out_free   = !out_valid_reg || drive.ready;
    assign final_fire = (state_reg == S_FINAL) && out_free;
    assign timed_now  = elapsed_reg > timeout_reg;

    // ramp region from the distance so far; past the distance check it is below 2^24
    assign t_ext        = CMP_W'(travelled_reg);
    assign dist_reached = t_ext >= CMP_W'(total_reg);
    assign in_accel     = (accel_reg != '0) && (t_ext <= CMP_W'(accel_reg));
    assign in_decel     = !in_accel && (decel_reg != '0)
                        && ((t_ext + CMP_W'(decel_reg)) >= CMP_W'(total_reg));
    assign x_next       = in_accel ? t_ext[TICK_WIDTH-1:0]
                                   : total_reg - t_ext[TICK_WIDTH-1:0];

    assign num       = NUM_WIDTH'(cruise_reg) * NUM_WIDTH'(x_reg);
    assign div_start = (state_reg == S_MUL) && (in_accel_reg || in_decel_reg);
    assign target    = (in_accel_reg || in_decel_reg) ? quot : cruise_reg;
    // ramp-down uses the dropped gain from its first tick on
    assign g_used    = (gain_dropped_reg || in_decel_reg) ? DROPPED_GAIN_Q8 : gain_reg;

    assign lane_ctl.load_mag  = (state_reg == S_SETUP);
    assign lane_ctl.load_err  = (state_reg == S_ERR);
    assign lane_ctl.load_prod = (state_reg == S_PROD);
    assign lane_ctl.commit    = final_fire && (kind_reg == K_RUN);
    assign lane_ctl.clear     = final_fire && (kind_reg == K_START);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = (tick.action && !finished_reg && !dist_reached)
                               ? S_SETUP : S_FINAL;
            S_SETUP: state_next = S_MUL;
            S_MUL:   state_next = (in_accel_reg || in_decel_reg) ? S_DIV : S_ERR;
            S_DIV:
                if (div_done)
                    state_next = S_ERR;
            S_ERR:   state_next = S_PROD;
            S_PROD:  state_next = S_FINAL;
            S_FINAL:
                if (out_free)
                    state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg     <= DIR_FWD;
            total_reg   <= TICK_WIDTH'(1000);
            cruise_reg  <= CRUISE_WIDTH'(20);
            base_reg    <= POWER_WIDTH'(60);
            accel_reg   <= TICK_WIDTH'(200);
            decel_reg   <= TICK_WIDTH'(200);
            gain_reg    <= GAIN_WIDTH'(256);
            timeout_reg <= TIME_WIDTH'(5000);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIRECTION: dir_reg     <= cfg_data[DIR_WIDTH-1:0];
                REG_TOTAL:     total_reg   <= cfg_data[TICK_WIDTH-1:0];
                REG_CRUISE:    cruise_reg  <= cfg_data[CRUISE_WIDTH-1:0];
                REG_BASE:      base_reg    <= signed'(cfg_data[POWER_WIDTH-1:0]);
                REG_ACCEL:     accel_reg   <= cfg_data[TICK_WIDTH-1:0];
                REG_DECEL:     decel_reg   <= cfg_data[TICK_WIDTH-1:0];
                REG_GAIN:      gain_reg    <= cfg_data[GAIN_WIDTH-1:0];
                REG_TIMEOUT:   timeout_reg <= cfg_data[TIME_WIDTH-1:0];
                default:       dir_reg     <= dir_reg;
            endcase
        end
    end

    // latch the word and classify it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            kind_reg <= K_START;
        else if (accept)
        begin
            if (!tick.action)
                kind_reg <= K_START;
            else if (finished_reg)
                kind_reg <= K_REPEAT;
            else if (dist_reached)
                kind_reg <= K_DIST;
            else
                kind_reg <= K_RUN;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            count_reg[0] <= tick.count_front_left;
            count_reg[1] <= tick.count_front_right;
            count_reg[2] <= tick.count_back_left;
            count_reg[3] <= tick.count_back_right;
            elapsed_reg  <= tick.elapsed_ms;
        end
        if (state_reg == S_SETUP)
        begin
            in_accel_reg <= in_accel;
            in_decel_reg <= in_decel;
            x_reg        <= x_next;
        end
    end

    // move state updates at the final stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            travelled_reg    <= '0;
            gain_dropped_reg <= 1'b0;
            finished_reg     <= 1'b0;
            timeout_flag_reg <= 1'b0;
        end
        else if (final_fire)
        begin
            case (kind_reg)
                K_START:
                begin
                    travelled_reg    <= '0;
                    gain_dropped_reg <= 1'b0;
                    finished_reg     <= 1'b0;
                    timeout_flag_reg <= 1'b0;
                end
                K_DIST:
                    finished_reg <= 1'b1;
                K_RUN:
                begin
                    travelled_reg <= travelled_new;
                    if (in_decel_reg)
                        gain_dropped_reg <= 1'b1;
                    if (timed_now)
                    begin
                        finished_reg     <= 1'b1;
                        timeout_flag_reg <= 1'b1;
                    end
                end
                default:
                    finished_reg <= finished_reg;
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (final_fire)
            out_valid_reg <= 1'b1;
        else if (drive.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (final_fire)
        begin
            for (int i = 0; i < NUM_WHEELS; i++)
                out_power_reg[i] <= ((kind_reg == K_RUN) && !timed_now) ? drive_power[i] : '0;
            case (kind_reg)
                K_START:
                begin
                    out_done_reg <= 1'b0;
                    out_to_reg   <= 1'b0;
                end
                K_RUN:
                begin
                    out_done_reg <= timed_now;
                    out_to_reg   <= timed_now;
                end
                default:
                begin
                    out_done_reg <= 1'b1;
                    out_to_reg   <= timeout_flag_reg;
                end
            endcase
        end
    end

    assign drive.valid             = out_valid_reg;
    assign drive.power_front_left  = out_power_reg[0];
    assign drive.power_front_right = out_power_reg[1];
    assign drive.power_back_left   = out_power_reg[2];
    assign drive.power_back_right  = out_power_reg[3];
    assign drive.done_res          = out_done_reg;
    assign drive.timed_out         = out_to_reg;

    pfwsd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num),
        .den   (in_accel_reg ? accel_reg : decel_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // front lanes take raw magnitudes, back lanes the scaled ones
    for (genvar w = 0; w < NUM_WHEELS; w++)
    begin : g_lane
        pfwsd_lane #(
            .COUNT_WIDTH (COUNT_WIDTH),
            .SCALED      (w >= 2)
        ) u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (lane_ctl),
            .count      (count_reg[w]),
            .target     (target),
            .gain       (g_used),
            .base_power (base_reg),
            .mag        (lane_mag[w]),
            .power      (lane_power[w])
        );
    end

    pfwsd_merge #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_merge (
        .mag       (lane_mag),
        .power_in  (lane_power),
        .dir       (dir_reg),
        .travelled (travelled_new),
        .power_out (drive_power)
    );
endmodule

// ===== src/pfwsd_div.sv =====
// restoring divider for the ramp target, one quotient bit per cycle
// depends on pfwsd_pkg; the dividend is below 256 times the divisor
module pfwsd_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic [pfwsd_pkg::NUM_WIDTH-1:0]     num,
    input  logic [pfwsd_pkg::TICK_WIDTH-1:0]    den,
    output logic                                done,
    output logic [pfwsd_pkg::QUOT_WIDTH-1:0]    quot
);
    import pfwsd_pkg::*;

    localparam int CNT_W = $clog2(QUOT_WIDTH);

    logic [NUM_WIDTH-1:0]  rem_reg, rem_next;
    logic [NUM_WIDTH-1:0]  dsh_reg, dsh_next;
    logic [QUOT_WIDTH-1:0] q_reg, q_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  fits;

    assign fits = rem_reg >= dsh_reg;
    assign done = busy_reg && (cnt_reg == '0);
    assign quot = q_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        dsh_next  = dsh_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = num;
            dsh_next  = {{(NUM_WIDTH-TICK_WIDTH-QUOT_WIDTH+1){1'b0}}, den,
                         {(QUOT_WIDTH-1){1'b0}}};
            q_next    = '0;
            cnt_next  = CNT_W'(QUOT_WIDTH-1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (fits)
                rem_next = rem_reg - dsh_reg;
            q_next   = {q_reg[QUOT_WIDTH-2:0], fits};
            dsh_next = dsh_reg >> 1;
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsh_reg <= dsh_next;
        q_reg   <= q_next;
    end
endmodule

// ===== src/pfwsd_lane.sv =====
// one wheel lane: magnitude, speed error, proportional product, saturated power
// depends on pfwsd_pkg; holds the wheel's last magnitude
module pfwsd_lane #(
    parameter int COUNT_WIDTH = pfwsd_pkg::COUNT_WIDTH_DEF,
    parameter bit SCALED      = 1'b0
) (
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  pfwsd_pkg::lane_ctl_t                        ctl,
    input  logic [pfwsd_pkg::PORT_COUNT_WIDTH-1:0]      count,
    input  logic [pfwsd_pkg::CRUISE_WIDTH-1:0]          target,
    input  logic [pfwsd_pkg::GAIN_WIDTH-1:0]            gain,
    input  logic signed [pfwsd_pkg::POWER_WIDTH-1:0]    base_power,
    output logic [COUNT_WIDTH-1:0]                      mag,
    output logic signed [pfwsd_pkg::POWER_WIDTH-1:0]    power
);
    import pfwsd_pkg::*;

    localparam int ERR_W  = COUNT_WIDTH + 2;
    localparam int PROD_W = ERR_W + GAIN_WIDTH + 1;
    localparam int SUM_W  = PROD_W + 1;
    localparam int SCL_W  = COUNT_WIDTH + 12;
    localparam logic signed [SUM_W-1:0] LIM_POS = SUM_W'(127);
    localparam logic signed [SUM_W-1:0] LIM_NEG = -SUM_W'(127);

    logic [COUNT_WIDTH-1:0]    mag_reg, last_reg;
    logic signed [ERR_W-1:0]   err_reg, err_next;
    logic signed [PROD_W-1:0]  prod_reg, prod_next;
    logic signed [COUNT_WIDTH-1:0] cnt_s;
    logic [COUNT_WIDTH-1:0]    abs_val, mag_next;
    logic [SCL_W-1:0]          scaled;
    logic signed [SUM_W-1:0]   base_ext, sum, quo;

    assign cnt_s   = signed'(count[COUNT_WIDTH-1:0]);
    assign abs_val = cnt_s[COUNT_WIDTH-1] ? COUNT_WIDTH'(-cnt_s) : COUNT_WIDTH'(cnt_s);
    // back wheels: magnitude times 1411/1024, the result still fits the count width
    assign scaled  = SCL_W'(abs_val) * SCL_W'(BACK_SCALE_Q10);
    assign mag_next = SCALED ? scaled[COUNT_WIDTH+9:10] : abs_val;

    assign err_next = signed'(ERR_W'(target))
                    - (signed'(ERR_W'(mag_reg)) - signed'(ERR_W'(last_reg)));
    assign prod_next = signed'({1'b0, gain}) * err_reg;

    // divide by 256 with truncation toward zero
    assign base_ext = SUM_W'(base_power) <<< 8;
    assign sum      = SUM_W'(prod_reg) + base_ext;

    always_comb
    begin
        quo = sum >>> 8;
        if (sum[SUM_W-1] && (sum[7:0] != 8'd0))
            quo = quo + SUM_W'(1);
        if (quo >= LIM_POS)
            power = POWER_WIDTH'(LIM_POS);
        else if (quo <= LIM_NEG)
            power = POWER_WIDTH'(LIM_NEG);
        else
            power = quo[POWER_WIDTH-1:0];
    end

    assign mag = mag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_reg <= '0;
        else if (ctl.clear)
            last_reg <= '0;
        else if (ctl.commit)
            last_reg <= mag_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load_mag)
            mag_reg <= mag_next;
        if (ctl.load_err)
            err_reg <= err_next;
        if (ctl.load_prod)
            prod_reg <= prod_next;
    end
endmodule

// ===== src/pfwsd_merge.sv =====
// merging stage: mean of the four magnitudes and the direction sign per wheel
// depends on pfwsd_pkg for the sign table
module pfwsd_merge #(
    parameter int COUNT_WIDTH = pfwsd_pkg::COUNT_WIDTH_DEF
) (
    input  logic [COUNT_WIDTH-1:0]                     mag [pfwsd_pkg::NUM_WHEELS],
    input  logic signed [pfwsd_pkg::POWER_WIDTH-1:0]   power_in [pfwsd_pkg::NUM_WHEELS],
    input  logic [pfwsd_pkg::DIR_WIDTH-1:0]            dir,
    output logic [COUNT_WIDTH-1:0]                     travelled,
    output logic signed [pfwsd_pkg::POWER_WIDTH-1:0]   power_out [pfwsd_pkg::NUM_WHEELS]
);
    import pfwsd_pkg::*;

    localparam int SUM_W = COUNT_WIDTH + 2;

    logic [SUM_W-1:0] mag_sum;
    sign_row_t        signs;

    assign mag_sum   = SUM_W'(mag[0]) + SUM_W'(mag[1]) + SUM_W'(mag[2]) + SUM_W'(mag[3]);
    assign travelled = mag_sum[SUM_W-1:2];
    assign signs     = wheel_signs(dir);

    always_comb
    begin
        for (int i = 0; i < NUM_WHEELS; i++)
        begin
            case (signs[i])
                SIGN_POS: power_out[i] = power_in[i];
                SIGN_NEG: power_out[i] = -power_in[i];
                default:  power_out[i] = '0;
            endcase
        end
    end
endmodule

// ===== src/pfwsd_checker.sv =====
// port-level checks on the speed drive: result word holding and power rules
// depends on pfwsd_pkg; bound to profiled_four_wheel_speed_drive_unit
module pfwsd_checker (
    input logic                                      clk,
    input logic                                      rst_n,
    input logic                                      out_valid,
    input logic                                      out_ready,
    input logic signed [pfwsd_pkg::POWER_WIDTH-1:0]  pfl,
    input logic signed [pfwsd_pkg::POWER_WIDTH-1:0]  pfr,
    input logic signed [pfwsd_pkg::POWER_WIDTH-1:0]  pbl,
    input logic signed [pfwsd_pkg::POWER_WIDTH-1:0]  pbr,
    input logic                                      done_res,
    input logic                                      timed_out
);
    import pfwsd_pkg::*;

    localparam logic signed [POWER_WIDTH-1:0] PMIN = -128;

    // a stalled result word stays
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable({pfl, pfr, pbl, pbr, done_res}))
        else $error("result word changed while stalled");

    // a finished move drives no wheel
    a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> (pfl == '0) && (pfr == '0) && (pbl == '0) && (pbr == '0))
        else $error("power on a done word");

    // timeout only ends a move
    a_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && timed_out |-> done_res)
        else $error("timed_out without done_res");

    // saturation keeps powers off the most negative code
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pfl != PMIN) && (pfr != PMIN) && (pbl != PMIN) && (pbr != PMIN))
        else $error("power outside saturation range");
endmodule

bind profiled_four_wheel_speed_drive_unit pfwsd_checker u_pfwsd_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (drive.valid),
    .out_ready (drive.ready),
    .pfl       (drive.power_front_left),
    .pfr       (drive.power_front_right),
    .pbl       (drive.power_back_left),
    .pbr       (drive.power_back_right),
    .done_res  (drive.done_res),
    .timed_out (drive.timed_out)
);
